[sv/pmsm_pkg.sv]
package pmsm_pkg;

    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int TWO_PI_Q  = 411775;
    localparam int DTH_MAX   = TWO_PI_Q - 1;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(25);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESISTANCE,
        REG_STEP_OVER_INDUCTANCE,
        REG_TIME_STEP,
        REG_STEP_OVER_INERTIA,
        REG_MAGNET_FLUX,
        REG_POLE_PAIRS,
        REG_FRICTION,
        REG_LOAD_TORQUE
    } cfg_reg_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_ID_RES,
        MUL_WE_IQ,
        MUL_IQ_RES,
        MUL_WE_FLUX,
        MUL_W_FRIC,
        MUL_WE_TS,
        MUL_ND_TSL,
        MUL_NQ_TSL,
        MUL_IQN_K,
        MUL_NW_TSJ
    } mul_sel_t;

    typedef enum logic [3:0] {
        ACC_NONE,
        ACC_WE,
        ACC_LOAD_ND,
        ACC_ADD_ND,
        ACC_LOAD_NQ,
        ACC_SUB_NQ,
        ACC_DTH,
        ACC_STORE_WB,
        ACC_IDN,
        ACC_IQN,
        ACC_TE,
        ACC_NW1,
        ACC_NW2,
        ACC_WN
    } acc_op_t;

    typedef struct packed {
        logic     capture;
        logic     load_out;
        mul_sel_t mul;
        acc_op_t  acc;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] volt_d;
        logic signed [31:0] volt_q;
    } step_in_t;

    typedef struct packed {
        logic signed [31:0] current_d;
        logic signed [31:0] current_q;
        logic signed [31:0] speed_mech;
        logic        [18:0] angle_elec;
        logic signed [31:0] torque_elec;
        logic signed [31:0] speed_elec;
    } result_t;

    // Multiplier results return through the operand, partial-product, sum and result registers after issue.
    function automatic cmd_t sched(input logic [STEP_W-1:0] step);
        cmd_t c;
        c.capture  = 1'b0;
        c.load_out = 1'b0;
        c.mul      = MUL_NONE;
        c.acc      = ACC_NONE;
        case (step)
            5'd0:
            begin
                c.acc = ACC_WE;
            end
            5'd1:
            begin
                c.mul = MUL_ID_RES;
            end
            5'd2:
            begin
                c.mul = MUL_WE_IQ;
            end
            5'd3:
            begin
                c.mul = MUL_IQ_RES;
            end
            5'd4:
            begin
                c.mul = MUL_WE_FLUX;
            end
            5'd5:
            begin
                c.mul = MUL_WE_TS;
                c.acc = ACC_LOAD_ND;
            end
            5'd6:
            begin
                c.mul = MUL_W_FRIC;
                c.acc = ACC_ADD_ND;
            end
            5'd7:
            begin
                c.mul = MUL_ND_TSL;
                c.acc = ACC_LOAD_NQ;
            end
            5'd8:
            begin
                c.acc = ACC_SUB_NQ;
            end
            5'd9:
            begin
                c.mul = MUL_NQ_TSL;
                c.acc = ACC_DTH;
            end
            5'd10:
            begin
                c.acc = ACC_STORE_WB;
            end
            5'd11:
            begin
                c.acc = ACC_IDN;
            end
            5'd13:
            begin
                c.acc = ACC_IQN;
            end
            5'd14:
            begin
                c.mul = MUL_IQN_K;
            end
            5'd18:
            begin
                c.acc = ACC_TE;
            end
            5'd19:
            begin
                c.acc = ACC_NW1;
            end
            5'd20:
            begin
                c.acc = ACC_NW2;
            end
            5'd21:
            begin
                c.mul = MUL_NW_TSJ;
            end
            5'd25:
            begin
                c.acc = ACC_WN;
            end
            default:
            begin
                c.acc = ACC_NONE;
            end
        endcase
        return c;
    endfunction

endpackage

[sv/pmsm_ctrl.sv]
module pmsm_ctrl
    import pmsm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step_valid,
    output logic step_stall,
    output logic result_valid,
    input  logic result_stall,
    output cmd_t cmd
);

    ctrl_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              full_reg, full_next;
    logic              load;

    assign load = (state_reg == ST_DONE) && (!full_reg || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            full_reg  <= full_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        full_next  = load || (full_reg && result_stall);
        case (state_reg)
            ST_IDLE:
            begin
                if (step_valid)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_DONE:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        step_stall   = 1'b1;
        result_valid = full_reg;
        cmd          = sched(step_reg);
        case (state_reg)
            ST_IDLE:
            begin
                step_stall = 1'b0;
                cmd.mul    = MUL_NONE;
                cmd.acc    = ACC_NONE;
                cmd.capture = step_valid;
            end
            ST_RUN:
            begin
                step_stall = 1'b1;
            end
            ST_DONE:
            begin
                cmd.mul      = MUL_NONE;
                cmd.acc      = ACC_NONE;
                cmd.load_out = load;
            end
            default:
            begin
                cmd.mul = MUL_NONE;
                cmd.acc = ACC_NONE;
            end
        endcase
    end

endmodule

[sv/pmsm_dp.sv]
module pmsm_dp
    import pmsm_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  step_in_t             step_data,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [47:0]          cfg_data,
    output result_t              result_data
);

    localparam int W = DATA_WIDTH;
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    typedef enum logic [1:0] {
        SH_16,
        SH_17,
        SH_48
    } shift_t;

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63])
        begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [W-1:0] satw(input logic signed [63:0] v);
        if (v[63:W-1] == {(65-W){v[63]}})
        begin
            return v[W-1:0];
        end
        return v[63] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    function automatic logic [31:0] o32(input logic signed [W-1:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        return e[31:0];
    endfunction

    // configuration
    logic        [31:0] resistance_reg;
    logic        [47:0] tsl_reg;
    logic        [47:0] ts_reg;
    logic        [47:0] tsj_reg;
    logic        [31:0] flux_reg;
    logic        [3:0]  pole_reg;
    logic        [31:0] friction_reg;
    logic signed [31:0] tl_reg;

    // plant state
    logic signed [W-1:0] cur_d_reg;
    logic signed [W-1:0] cur_q_reg;
    logic signed [W-1:0] speed_reg;
    logic        [18:0]  angle_reg;

    // working registers
    logic signed [31:0]  vd_reg;
    logic signed [31:0]  vq_reg;
    logic signed [W-1:0] we_reg;
    logic signed [W-1:0] te_reg;
    logic        [37:0]  k_reg;
    logic signed [63:0]  num_d_reg;
    logic signed [63:0]  num_q_reg;
    logic signed [63:0]  num_w_reg;
    logic signed [63:0]  wb_reg;
    result_t             result_reg;

    // multiplier pipeline
    logic        [63:0]  ma_reg;
    logic        [47:0]  mb_reg;
    logic                neg0_reg, neg1_reg, neg2_reg;
    shift_t              sh0_reg, sh1_reg, sh2_reg;
    logic        [63:0]  pp_ll_reg;
    logic        [47:0]  pp_lh_reg;
    logic        [63:0]  pp_hl_reg;
    logic        [47:0]  pp_hh_reg;
    logic        [111:0] prod_reg;
    logic signed [63:0]  mres_reg;

    logic signed [63:0]  opa;
    logic signed [48:0]  opb;
    shift_t              sh_sel;
    logic        [111:0] shifted;
    logic        [63:0]  mag;
    logic signed [W+4:0] pw;
    logic        [35:0]  pf;
    logic signed [19:0]  dth;
    logic signed [20:0]  th_sum;
    logic signed [20:0]  th_fix;
    logic signed [63:0]  neg_m;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resistance_reg <= '0;
            tsl_reg        <= '0;
            ts_reg         <= '0;
            tsj_reg        <= '0;
            flux_reg       <= '0;
            pole_reg       <= 4'd4;
            friction_reg   <= '0;
            tl_reg         <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RESISTANCE:           resistance_reg <= cfg_data[31:0];
                REG_STEP_OVER_INDUCTANCE: tsl_reg        <= cfg_data;
                REG_TIME_STEP:            ts_reg         <= cfg_data;
                REG_STEP_OVER_INERTIA:    tsj_reg        <= cfg_data;
                REG_MAGNET_FLUX:          flux_reg       <= cfg_data[31:0];
                REG_POLE_PAIRS:           pole_reg       <= cfg_data[3:0];
                REG_FRICTION:             friction_reg   <= cfg_data[31:0];
                REG_LOAD_TORQUE:          tl_reg         <= $signed(cfg_data[31:0]);
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        opa    = '0;
        opb    = '0;
        sh_sel = SH_16;
        case (cmd.mul)
            MUL_ID_RES:
            begin
                opa = 64'(cur_d_reg);
                opb = 49'(resistance_reg);
            end
            MUL_WE_IQ:
            begin
                opa = 64'(we_reg);
                opb = 49'(cur_q_reg);
            end
            MUL_IQ_RES:
            begin
                opa = 64'(cur_q_reg);
                opb = 49'(resistance_reg);
            end
            MUL_WE_FLUX:
            begin
                opa = 64'(we_reg);
                opb = 49'(flux_reg);
            end
            MUL_W_FRIC:
            begin
                opa = 64'(speed_reg);
                opb = 49'(friction_reg);
            end
            MUL_WE_TS:
            begin
                opa    = 64'(we_reg);
                opb    = 49'(ts_reg);
                sh_sel = SH_48;
            end
            MUL_ND_TSL:
            begin
                opa    = num_d_reg;
                opb    = 49'(tsl_reg);
                sh_sel = SH_48;
            end
            MUL_NQ_TSL:
            begin
                opa    = num_q_reg;
                opb    = 49'(tsl_reg);
                sh_sel = SH_48;
            end
            MUL_IQN_K:
            begin
                opa    = 64'(cur_q_reg);
                opb    = 49'(k_reg);
                sh_sel = SH_17;
            end
            MUL_NW_TSJ:
            begin
                opa    = num_w_reg;
                opb    = 49'(tsj_reg);
                sh_sel = SH_48;
            end
            default:
            begin
                opa = '0;
            end
        endcase
    end

    always_comb
    begin
        case (sh2_reg)
            SH_16:   shifted = prod_reg >> 16;
            SH_17:   shifted = prod_reg >> 17;
            SH_48:   shifted = prod_reg >> 48;
            default: shifted = prod_reg >> 16;
        endcase
        mag = (|shifted[111:63]) ? 64'(S64_MAX) : {1'b0, shifted[62:0]};
    end

    always_ff @(posedge clk)
    begin
        ma_reg    <= opa[63] ? 64'(-opa) : 64'(opa);
        mb_reg    <= opb[48] ? 48'(-opb) : 48'(opb);
        neg0_reg  <= opa[63] ^ opb[48];
        sh0_reg   <= sh_sel;

        pp_ll_reg <= ma_reg[31:0] * mb_reg[31:0];
        pp_lh_reg <= ma_reg[31:0] * mb_reg[47:32];
        pp_hl_reg <= ma_reg[63:32] * mb_reg[31:0];
        pp_hh_reg <= ma_reg[63:32] * mb_reg[47:32];
        neg1_reg  <= neg0_reg;
        sh1_reg   <= sh0_reg;

        prod_reg  <= 112'(pp_ll_reg) + (112'(pp_lh_reg) << 32)
                   + (112'(pp_hl_reg) << 32) + (112'(pp_hh_reg) << 64);
        neg2_reg  <= neg1_reg;
        sh2_reg   <= sh1_reg;

        mres_reg  <= neg2_reg ? -$signed(mag) : $signed(mag);
    end

    always_comb
    begin
        neg_m = -mres_reg;
        pw    = $signed({1'b0, pole_reg}) * speed_reg;
        pf    = pole_reg * flux_reg;
        if (mres_reg > 64'(DTH_MAX))
        begin
            dth = 20'(DTH_MAX);
        end
        else if (mres_reg < -64'(DTH_MAX))
        begin
            dth = -20'(DTH_MAX);
        end
        else
        begin
            dth = mres_reg[19:0];
        end
        th_sum = $signed({2'b00, angle_reg}) + 21'(dth);
        if (th_sum >= 21'(TWO_PI_Q))
        begin
            th_fix = th_sum - 21'(TWO_PI_Q);
        end
        else if (th_sum < 21'sd0)
        begin
            th_fix = th_sum + 21'(TWO_PI_Q);
        end
        else
        begin
            th_fix = th_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            vd_reg <= step_data.volt_d;
            vq_reg <= step_data.volt_q;
        end
        case (cmd.acc)
            ACC_WE:
            begin
                we_reg <= satw(64'(pw));
                k_reg  <= 38'(pf) + (38'(pf) << 1);
            end
            ACC_LOAD_ND:  num_d_reg <= sadd(64'(vd_reg), neg_m);
            ACC_ADD_ND:   num_d_reg <= sadd(num_d_reg, mres_reg);
            ACC_LOAD_NQ:  num_q_reg <= sadd(64'(vq_reg), neg_m);
            ACC_SUB_NQ:   num_q_reg <= sadd(num_q_reg, neg_m);
            ACC_STORE_WB: wb_reg    <= mres_reg;
            ACC_TE:       te_reg    <= satw(mres_reg);
            ACC_NW1:      num_w_reg <= sadd(64'(te_reg), -wb_reg);
            ACC_NW2:      num_w_reg <= sadd(num_w_reg, -64'(tl_reg));
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_d_reg <= '0;
            cur_q_reg <= '0;
            speed_reg <= '0;
            angle_reg <= '0;
        end
        else
        begin
            case (cmd.acc)
                ACC_IDN:  cur_d_reg <= satw(sadd(64'(cur_d_reg), mres_reg));
                ACC_IQN:  cur_q_reg <= satw(sadd(64'(cur_q_reg), mres_reg));
                ACC_WN:   speed_reg <= satw(sadd(64'(speed_reg), mres_reg));
                ACC_DTH:  angle_reg <= th_fix[18:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result_reg.current_d   <= o32(cur_d_reg);
            result_reg.current_q   <= o32(cur_q_reg);
            result_reg.speed_mech  <= o32(speed_reg);
            result_reg.angle_elec  <= angle_reg;
            result_reg.torque_elec <= o32(te_reg);
            result_reg.speed_elec  <= o32(we_reg);
        end
    end

    assign result_data = result_reg;

endmodule

[sv/pmsm_dq_euler_step.sv]
// The fixed 26-step schedule runs in ST_RUN around the shared 4-stage
// 64x48 multiplier and its chained dependencies; no new item is taken
// until ST_DONE has loaded the result into the output register.
// A finished result waits in the output register while the next item runs.
// Reset (rst_n, asynchronous, active low) clears currents, speed and angle,
// zeroes the other configuration registers and sets pole_pairs to 4.
module pmsm_dq_euler_step
    import pmsm_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_valid,
    output logic                 step_stall,
    input  step_in_t             step_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [47:0]          cfg_data
);

    cmd_t cmd;

    assign cfg_ready = 1'b1;

    pmsm_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_valid   (step_valid),
        .step_stall   (step_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    pmsm_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .step_data   (step_data),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .result_data (result_data)
    );

endmodule
